>>> rtl/core/tsct_pkg.sv
// ---------------------------------------------------------------------------
// Sine, cosine and tangent unit package
// Shared types, function codes, phase constants and the half-wave table.
// ---------------------------------------------------------------------------
`default_nettype none

package tsct_pkg;

  typedef enum logic [1:0] {
    FN_SIN = 2'd0,
    FN_COS = 2'd1,
    FN_TAN = 2'd2
  } tsct_func_e;

  typedef struct packed {
    logic [1:0]          req_type;
    logic signed [31:0]  angle;
  } tsct_req_t;

  typedef struct packed {
    logic signed [31:0]  value;
    logic                status;
  } tsct_rsp_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [23:0] phase;
  } tsct_item_t;

  localparam logic [31:0] INV_PI_Q32   = 32'd1367130551;
  localparam logic [15:0] INV_PI_LO    = INV_PI_Q32[15:0];
  localparam logic [15:0] INV_PI_HI    = INV_PI_Q32[31:16];
  localparam logic [23:0] QUARTER_TURN = 24'h40_0000;
  // Division by the table scale is a shift by nine, then a multiplication
  // by the reciprocal of 125 scaled by 2^31.
  localparam logic [24:0] RECIP_SCALE  = 25'd17179870;
  localparam logic [32:0] HALF_SCALE   = 33'd32000;
  localparam int unsigned DIV_STEPS    = 4;

  localparam logic [15:0] WAVE_TAB [129] = '{
    16'd0, 16'd1571, 16'd3140, 16'd4708, 16'd6273, 16'd7834, 16'd9391, 16'd10942,
    16'd12486, 16'd14022, 16'd15551, 16'd17070, 16'd18578, 16'd20076, 16'd21561,
    16'd23033, 16'd24492, 16'd25935, 16'd27364, 16'd28775, 16'd30169, 16'd31545,
    16'd32903, 16'd34240, 16'd35556, 16'd36852, 16'd38125, 16'd39375, 16'd40601,
    16'd41803, 16'd42980, 16'd44131, 16'd45255, 16'd46352, 16'd47421, 16'd48461,
    16'd49473, 16'd50454, 16'd51405, 16'd52325, 16'd53214, 16'd54071, 16'd54895,
    16'd55686, 16'd56443, 16'd57166, 16'd57855, 16'd58509, 16'd59128, 16'd59712,
    16'd60259, 16'd60770, 16'd61244, 16'd61682, 16'd62082, 16'd62445, 16'd62770,
    16'd63058, 16'd63307, 16'd63519, 16'd63692, 16'd63827, 16'd63923, 16'd63981,
    16'd64000, 16'd63981, 16'd63923, 16'd63827, 16'd63692, 16'd63519, 16'd63307,
    16'd63058, 16'd62770, 16'd62445, 16'd62082, 16'd61682, 16'd61244, 16'd60770,
    16'd60259, 16'd59712, 16'd59128, 16'd58509, 16'd57855, 16'd57166, 16'd56443,
    16'd55686, 16'd54895, 16'd54071, 16'd53214, 16'd52325, 16'd51405, 16'd50454,
    16'd49473, 16'd48461, 16'd47421, 16'd46352, 16'd45255, 16'd44131, 16'd42980,
    16'd41803, 16'd40601, 16'd39375, 16'd38125, 16'd36852, 16'd35556, 16'd34240,
    16'd32903, 16'd31545, 16'd30169, 16'd28775, 16'd27364, 16'd25935, 16'd24492,
    16'd23033, 16'd21561, 16'd20076, 16'd18578, 16'd17070, 16'd15551, 16'd14022,
    16'd12486, 16'd10942, 16'd9391, 16'd7834, 16'd6273, 16'd4708, 16'd3140,
    16'd1571, 16'd0
  };

endpackage

`default_nettype wire

>>> rtl/core/tsct_front.sv
// ---------------------------------------------------------------------------
// Front end
// Accepts requests and converts the angle to a 24-bit full-turn phase.
// ---------------------------------------------------------------------------
`default_nettype none

module tsct_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire tsct_pkg::tsct_req_t in_data_i,
  output logic                     push_valid_o,
  input  wire logic                push_ready_i,
  output tsct_pkg::tsct_item_t     push_data_o
);
  import tsct_pkg::*;

  logic               a_valid_q;
  logic [48:0]        p0_q;
  logic [32:0]        p1_q;
  logic [1:0]         sel_q;
  logic signed [48:0] p0_d;
  logic signed [48:0] p1_d;
  logic [48:0]        prod;

  assign in_ready_o = !a_valid_q || push_ready_i;
  assign p0_d = in_data_i.angle * $signed({1'b0, INV_PI_LO});
  assign p1_d = in_data_i.angle * $signed({1'b0, INV_PI_HI});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      p0_q  <= p0_d;
      p1_q  <= p1_d[32:0];
      sel_q <= in_data_i.req_type;
    end
  end

  assign prod = p0_q + {p1_q, 16'b0};
  assign push_valid_o = a_valid_q;
  assign push_data_o.req_type = sel_q;
  assign push_data_o.phase = prod[48:25];

endmodule

`default_nettype wire

>>> rtl/core/tsct_fifo.sv
// ---------------------------------------------------------------------------
// Item queue
// Short queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module tsct_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_valid_i,
  output logic                      push_ready_o,
  input  wire tsct_pkg::tsct_item_t push_data_i,
  output logic                      pop_valid_o,
  input  wire logic                 pop_ready_i,
  output tsct_pkg::tsct_item_t      pop_data_o
);
  import tsct_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tsct_item_t       mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != CW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH)) else $error("queue count beyond depth");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + CW'(1)) else $error("queue count lost a push");
  a_cnt_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> cnt_q == $past(cnt_q) - CW'(1)) else $error("queue count lost a pop");

endmodule

`default_nettype wire

>>> rtl/core/tsct_udiv.sv
// ---------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring long division, STEPS quotient bits per stage, with sideband.
// ---------------------------------------------------------------------------
`default_nettype none

module tsct_udiv #(
  parameter int unsigned DW    = 33,
  parameter int unsigned VW    = 16,
  parameter int unsigned SW    = 1,
  parameter int unsigned STEPS = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [DW-1:0]      quot_o,
  output logic [SW-1:0]      side_o
);
  localparam int unsigned NS = (DW + STEPS - 1) / STEPS;

  logic [NS-1:0] vld_q;
  logic [DW-1:0] num_q [NS];
  logic [VW-1:0] rem_q [NS];
  logic [VW-1:0] dvs_q [NS];
  logic [SW-1:0] side_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [DW-1:0] num_in, num_d;
    logic [VW-1:0] rem_in, rem_d, dvs_in;
    logic [SW-1:0] side_in;
    logic          vld_in;

    if (s == 0) begin : g_first
      assign num_in  = dividend_i;
      assign rem_in  = '0;
      assign dvs_in  = divisor_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign num_in  = num_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign dvs_in  = dvs_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    always_comb begin : p_steps
      logic [VW:0] trial;
      num_d = num_in;
      rem_d = rem_in;
      trial = '0;
      for (int j = 0; j < STEPS; j++) begin
        if (s * STEPS + j < DW) begin
          trial = {rem_d, num_d[DW-1]};
          num_d = {num_d[DW-2:0], 1'b0};
          if (trial >= {1'b0, dvs_in}) begin
            trial    = trial - {1'b0, dvs_in};
            num_d[0] = 1'b1;
          end
          rem_d = trial[VW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s]  <= num_d;
        rem_q[s]  <= rem_d;
        dvs_q[s]  <= dvs_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quot_o  = num_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

`default_nettype wire

>>> rtl/core/tsct_back.sv
// ---------------------------------------------------------------------------
// Back end
// Table lookup, interpolation, rescaling, tangent division and result.
// ---------------------------------------------------------------------------
`default_nettype none

module tsct_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 pop_valid_i,
  output logic                      pop_ready_o,
  input  wire tsct_pkg::tsct_item_t pop_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output tsct_pkg::tsct_rsp_t       out_data_o
);
  import tsct_pkg::*;

  typedef struct packed {
    logic [1:0]         sel;
    logic signed [17:0] s;
    logic signed [17:0] c;
    logic               neg;
    logic               czero;
  } tan_side_t;

  logic        en;
  logic        out_valid_q;
  tsct_rsp_t   out_q, out_d;

  logic [23:0] ph [2];
  logic [15:0] a_q [2], b_q [2], frac_q [2];
  logic        neg1_q [2];
  logic [1:0]  sel1_q;
  logic        v1_q;

  logic [32:0] x_d [2], x_q [2];
  logic        neg2_q [2];
  logic [1:0]  sel2_q;
  logic        v2_q;

  logic [16:0] mag_d [2], mag_q [2];
  logic        neg3_q [2];
  logic [1:0]  sel3_q;
  logic        vm_q;

  logic        v3_q;
  logic [32:0] dvd_q;
  logic [16:0] dvs_q;
  tan_side_t   t3_q, t3_d;

  logic        d2_valid;
  logic [32:0] quo;
  tan_side_t   t4;

  assign en = !out_valid_q || out_ready_i;
  assign pop_ready_o = en;

  assign ph[0] = pop_data_i.phase;
  assign ph[1] = pop_data_i.phase + QUARTER_TURN;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      vm_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= pop_valid_i;
      v2_q        <= v1_q;
      vm_q        <= v2_q;
      v3_q        <= vm_q;
      out_valid_q <= d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        a_q[l]    <= WAVE_TAB[{1'b0, ph[l][22:16]}];
        b_q[l]    <= WAVE_TAB[{1'b0, ph[l][22:16]} + 8'd1];
        frac_q[l] <= ph[l][15:0];
        neg1_q[l] <= ph[l][23];
        x_q[l]    <= x_d[l];
        neg2_q[l] <= neg1_q[l];
        mag_q[l]  <= mag_d[l];
        neg3_q[l] <= neg2_q[l];
      end
      sel1_q <= pop_data_i.req_type;
      sel2_q <= sel1_q;
      sel3_q <= sel2_q;
      t3_q   <= t3_d;
      dvd_q  <= {mag_q[0], 16'b0} + {17'b0, mag_q[1][16:1]};
      dvs_q  <= (mag_q[1] == '0) ? 17'd1 : mag_q[1];
      out_q  <= out_d;
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin : p_interp
      logic signed [16:0] diff;
      logic signed [33:0] prod;
      logic signed [33:0] num;
      diff  = $signed({1'b0, b_q[l]}) - $signed({1'b0, a_q[l]});
      prod  = diff * $signed({1'b0, frac_q[l]});
      num   = $signed({2'b0, a_q[l], 16'b0}) + prod;
      x_d[l] = num[32:0] + HALF_SCALE;
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin : p_rescale
      logic [48:0] rp;
      rp = x_q[l][32:9] * RECIP_SCALE;
      mag_d[l] = rp[47:31];
    end
  end

  always_comb begin
    logic s_neg, c_neg;
    s_neg = neg3_q[0] && (mag_q[0] != '0);
    c_neg = neg3_q[1] && (mag_q[1] != '0);
    t3_d.sel   = sel3_q;
    t3_d.s     = s_neg ? -$signed({1'b0, mag_q[0]}) : $signed({1'b0, mag_q[0]});
    t3_d.c     = c_neg ? -$signed({1'b0, mag_q[1]}) : $signed({1'b0, mag_q[1]});
    t3_d.neg   = s_neg != c_neg;
    t3_d.czero = mag_q[1] == '0;
  end

  tsct_udiv #(.DW(33), .VW(17), .SW($bits(tan_side_t)), .STEPS(DIV_STEPS)) u_div_tan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v3_q),
    .dividend_i (dvd_q),
    .divisor_i  (dvs_q),
    .side_i     (t3_q),
    .valid_o    (d2_valid),
    .quot_o     (quo),
    .side_o     (t4)
  );

  always_comb begin
    out_d.value  = '0;
    out_d.status = 1'b0;
    case (t4.sel)
      FN_SIN: out_d.value = 32'(t4.s);
      FN_COS: out_d.value = 32'(t4.c);
      FN_TAN: begin
        if (t4.czero) begin
          out_d.value  = t4.s[17] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          out_d.status = 1'b1;
        end else if (!t4.neg && quo > 33'h0_7FFF_FFFF) begin
          out_d.value  = 32'sh7FFF_FFFF;
          out_d.status = 1'b1;
        end else if (t4.neg && quo > 33'h0_8000_0000) begin
          out_d.value  = 32'sh8000_0000;
          out_d.status = 1'b1;
        end else begin
          out_d.value = t4.neg ? -$signed(quo[31:0]) : $signed(quo[31:0]);
        end
      end
      default: begin
        out_d.value  = '0;
        out_d.status = 1'b0;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/core/table_sine_cosine_tangent_unit.sv
// ---------------------------------------------------------------------------
// Table sine, cosine and tangent unit
// Items pass the front register, queue, back-end stages, divider and output.
// One item per cycle unless the output stalls; the divider is fully pipelined.
// The queue lets the front accept during output stalls until the queue is full.
// Reset clears the pipeline valid flags and the queue; nothing else is held.
// ---------------------------------------------------------------------------
`default_nettype none

module table_sine_cosine_tangent_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire tsct_pkg::tsct_req_t in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output tsct_pkg::tsct_rsp_t      out_data_o
);
  import tsct_pkg::*;

  logic       push_valid, push_ready, pop_valid, pop_ready;
  tsct_item_t push_data, pop_data;

  tsct_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  tsct_fifo #(.DEPTH(QueueDepth)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  tsct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> tb/table_sine_cosine_tangent_unit_tb.sv
// ---------------------------------------------------------------------------
// Table sine, cosine and tangent unit testbench
// Drives angle items with random idling on both channels, predicts each
// result not fixed in its row from the half-wave table and checks in order.
// ---------------------------------------------------------------------------
`default_nettype none

module table_sine_cosine_tangent_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsct_pkg::*;

  localparam int unsigned NumRandom = 600;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles = 40;

  typedef struct {
    tsct_req_t req;
    logic      has_result;
    tsct_rsp_t result;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  tsct_req_t in_data;
  logic      out_valid;
  logic      out_ready;
  tsct_rsp_t out_data;

  tsct_rsp_t expected_q[$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles;
  int unsigned stall_left;
  bit          calm;

  table_sine_cosine_tangent_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [23:0] to_phase(logic signed [31:0] ang);
    logic signed [63:0] prod;
    prod = 64'(ang) * 64'sd1367130551;
    return prod[48:25];
  endfunction

  function automatic longint table_sine(logic [23:0] ph);
    int unsigned idx;
    longint      a;
    longint      b;
    longint      num;
    longint      mag;
    idx = ph[22:16];
    a = longint'(WAVE_TAB[idx]);
    b = longint'(WAVE_TAB[idx + 1]);
    num = a * 65536 + (b - a) * longint'(ph[15:0]);
    mag = (num + 32000) / 64000;
    return ph[23] ? -mag : mag;
  endfunction

  function automatic tsct_rsp_t trig_result(tsct_req_t req);
    tsct_rsp_t   r;
    logic [23:0] ph;
    longint      s;
    longint      c;
    longint      n;
    longint      q;
    bit          neg;
    ph = to_phase(req.angle);
    s = table_sine(ph);
    c = table_sine(ph + QUARTER_TURN);
    r.value = '0;
    r.status = 1'b0;
    case (req.req_type)
      FN_SIN: r.value = 32'(s);
      FN_COS: r.value = 32'(c);
      FN_TAN: begin
        if (c == 0) begin
          r.value = (s >= 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
          r.status = 1'b1;
        end else begin
          n = s * 65536;
          neg = (n < 0) != (c < 0);
          if (n < 0) n = -n;
          if (c < 0) c = -c;
          q = (n + c / 2) / c;
          if (!neg && q > 64'sd2147483647) begin
            r.value = 32'h7FFF_FFFF;
            r.status = 1'b1;
          end else if (neg && q > 64'sd2147483648) begin
            r.value = 32'h8000_0000;
            r.status = 1'b1;
          end else begin
            r.value = 32'(neg ? -q : q);
          end
        end
      end
      default: r.value = '0;
    endcase
    return r;
  endfunction

  function automatic stim_row_t row(logic [1:0] t, logic [31:0] a, logic h = 1'b0,
                                    logic [31:0] v = '0, logic st = 1'b0);
    stim_row_t s;
    s.req.req_type = t;
    s.req.angle = a;
    s.has_result = h;
    s.result.value = v;
    s.result.status = st;
    return s;
  endfunction

  task automatic send_item(tsct_req_t req, stim_row_t r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(r.has_result ? r.result : trig_result(req));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no expectation: value %0d", out_data.value);
          fail_count++;
        end else begin
          if (out_data.value !== expected_q[0].value) begin
            $error("value: expected %0d, actual %0d", expected_q[0].value, out_data.value);
            fail_count++;
          end
          if (out_data.status !== expected_q[0].status) begin
            $error("status: expected %0b, actual %0b", expected_q[0].status,
                   out_data.status);
            fail_count++;
          end
          void'(expected_q.pop_front());
        end
      end
      if (calm) begin
        out_ready <= 1'b1;
      end else if (stall_left > 1) begin
        stall_left <= stall_left - 1;
      end else if (!out_ready) begin
        out_ready  <= 1'b1;
        stall_left <= 0;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(1, 8);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("** table_sine_cosine_tangent_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t   directed[$];
    tsct_req_t   req;
    stim_row_t   none;
    int unsigned pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    calm = 1'b0;
    none = row(FN_SIN, '0);

    directed.push_back(row(FN_SIN, 32'd0, 1'b1, 32'd0, 1'b0));
    directed.push_back(row(FN_COS, 32'd0, 1'b1, 32'd65536, 1'b0));
    directed.push_back(row(FN_TAN, 32'd0, 1'b1, 32'd0, 1'b0));
    directed.push_back(row(2'd3, 32'h1234_5678, 1'b1, 32'd0, 1'b0));
    directed.push_back(row(2'd3, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0));
    directed.push_back(row(FN_SIN, 32'h7FFF_FFFF));
    directed.push_back(row(FN_SIN, 32'h8000_0000));
    directed.push_back(row(FN_COS, 32'h7FFF_FFFF));
    directed.push_back(row(FN_COS, 32'h8000_0000));
    directed.push_back(row(FN_TAN, 32'h7FFF_FFFF));
    directed.push_back(row(FN_TAN, 32'h8000_0000));
    directed.push_back(row(FN_SIN, 32'd102944));
    directed.push_back(row(FN_SIN, 32'd205887));
    directed.push_back(row(FN_SIN, 32'd411775));
    directed.push_back(row(FN_SIN, 32'd411774));
    directed.push_back(row(FN_SIN, -32'sd411775));
    directed.push_back(row(FN_TAN, 32'd102944));
    directed.push_back(row(FN_TAN, 32'd102943));
    directed.push_back(row(FN_TAN, 32'd102945));
    directed.push_back(row(FN_TAN, -32'sd102944));
    directed.push_back(row(FN_TAN, 32'd308831));
    directed.push_back(row(FN_COS, 32'd205887));
    directed.push_back(row(FN_TAN, 32'd51472));
    directed.push_back(row(FN_SIN, 32'hFFFF_FFFF));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) send_item(directed[k].req, directed[k]);

    for (int unsigned k = 0; k < NumRandom; k++) begin
      if (k == NumRandom - 100) calm = 1'b1;
      pick = $urandom_range(0, 9);
      req.req_type = (pick == 0) ? 2'd3 : tsct_func_e'(pick % 3);
      case ($urandom_range(0, 3))
        0: req.angle = $urandom();
        1: req.angle = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        2: req.angle = 32'd102944 * $urandom_range(0, 8) + $urandom_range(0, 8) - 4;
        default: req.angle = $urandom_range(0, 32'h0006_5000) - 32'h0003_2800;
      endcase
      send_item(req, none);
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("** table_sine_cosine_tangent_unit: PASSED **");
    end else begin
      $display("** table_sine_cosine_tangent_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
